// File: rtl/core/mlto_pkg.sv
// Shared types and constants of the motor load torque observer.
package mlto_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOAD_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PER   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PER_OVER_INR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOAD_LIMIT   = 3'd4;

  // Register values after reset.
  localparam logic [31:0] SAMPLE_PER_RST   = 32'd214748;
  localparam logic [31:0] PER_OVER_INR_RST = 32'd16777216;
  localparam logic [30:0] LOAD_LIMIT_RST   = 31'd196608;

  // Signed Q16.16 quantity.
  typedef logic signed [31:0] q16_t;

  // Operands and results of the shared multiplier.
  typedef logic signed [33:0] mul_op_t;
  typedef logic signed [67:0] mul_acc_t;

endpackage

// File: rtl/core/motor_load_torque_observer_top.sv
// Luenberger load torque observer: one speed/torque transaction in, one estimate transaction out.
//
// Each accepted measurement transaction is worked by the single shared 34 x 17 signed
// multiplier, which forms each of the four wide products (speed error times period, the two
// gain corrections and the mechanical increment) in three chunks of one operand: two
// unsigned 16-bit pieces, then the signed top two bits. A state between products does the
// clamping and operand setup, and the moving average division by the window length (10 by
// default) retires eight quotient bits per cycle. The moving average window lives in a
// small RAM that is read once when a transaction is accepted and written once when it
// retires; entries not yet written since reset read as zero through per-entry valid bits,
// so no clearing pass is needed. While a finished estimate transaction waits on
// estimate_stall, the next measurement is still accepted and computed; it only holds in its
// finish state until the output register is free. Configuration writes must be issued only
// while no transaction is in flight.
module motor_load_torque_observer_top
  import mlto_pkg::*;
#(
  parameter int WINDOW_LEN = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  measure_valid,
  output logic                  measure_stall,
  input  logic signed [31:0]    measured_speed,
  input  logic signed [31:0]    drive_torque,
  output logic                  estimate_valid,
  input  logic                  estimate_stall,
  output logic signed [31:0]    speed_estimate,
  output logic signed [31:0]    load_estimate
);

  // Window geometry. The running total of WINDOW_LEN signed 32-bit entries needs
  // 32 + clog2(WINDOW_LEN) bits. The divider works on whole bytes of its magnitude.
  localparam int POS_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int TOT_W     = 32 + $clog2(WINDOW_LEN);
  localparam int DIV_STEPS = (TOT_W + 7) / 8;
  localparam int DIV_W     = DIV_STEPS * 8;
  localparam int REM_W     = $clog2(WINDOW_LEN + 1) + 1;
  localparam int DCNT_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(WINDOW_LEN - 1);
  localparam logic [REM_W-1:0]  DIVISOR   = REM_W'(WINDOW_LEN);
  localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(DIV_STEPS - 1);

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_MUL_ERR   = 11'b000_0000_0010,
    S_SET_LOADG = 11'b000_0000_0100,
    S_MUL_LOADG = 11'b000_0000_1000,
    S_CLAMP     = 11'b000_0001_0000,
    S_MUL_SPDG  = 11'b000_0010_0000,
    S_SET_TORQ  = 11'b000_0100_0000,
    S_MUL_TORQ  = 11'b000_1000_0000,
    S_SUM       = 11'b001_0000_0000,
    S_DIVIDE    = 11'b010_0000_0000,
    S_FINISH    = 11'b100_0000_0000
  } state_t;

  // Configuration registers.
  logic signed [31:0] speed_gain;
  logic signed [31:0] load_gain;
  logic [31:0]        sample_period;
  logic [31:0]        period_over_inertia;
  logic [30:0]        load_limit;

  // Observer state.
  q16_t                    speed_est;
  q16_t                    load_est;
  logic signed [TOT_W-1:0] window_total;
  logic [POS_W-1:0]        window_pos;
  logic [WINDOW_LEN-1:0]   win_valid;

  // Sequencer.
  state_t            state;
  state_t            state_next;
  logic [1:0]        mul_cnt;
  logic [DCNT_W-1:0] div_cnt;

  // Datapath registers.
  q16_t                    torque;
  mul_op_t                 mul_a;
  mul_op_t                 mul_b;
  logic signed [50:0]      prod;
  mul_acc_t                acc;
  mul_op_t                 err;
  q16_t                    load_val;
  logic signed [47:0]      corr;
  q16_t                    speed_new;
  logic signed [TOT_W-1:0] total_upd;
  logic [DIV_W-1:0]        div_q;
  logic [REM_W-1:0]        div_rem;
  logic                    div_neg;

  // Combinational values.
  logic                    accept;
  logic                    mul_active;
  logic                    retire;
  logic signed [16:0]      chunk;
  mul_acc_t                acc_sum;
  logic signed [48:0]      load_sum;
  logic signed [48:0]      lim_pos;
  q16_t                    load_clamped;
  logic signed [49:0]      speed_sum;
  q16_t                    speed_sat;
  q16_t                    old_entry;
  logic signed [TOT_W-1:0] total_sum;
  logic [TOT_W-1:0]        total_mag;
  logic [DIV_W-1:0]        div_q_step;
  logic [REM_W-1:0]        div_rem_step;
  logic [31:0]             quot;
  q16_t                    avg;
  logic [31:0]             ram_rdata;

  assign measure_stall = rst || (state != S_IDLE);
  assign accept        = measure_valid && !measure_stall;
  assign mul_active    = (state == S_MUL_ERR) || (state == S_MUL_LOADG) ||
                         (state == S_MUL_SPDG) || (state == S_MUL_TORQ);
  assign retire        = (state == S_FINISH) && (!estimate_valid || !estimate_stall);

  // The window RAM is read at the oldest position when a transaction is accepted and the
  // data stays on the read port until the transaction retires and overwrites that entry.
  mlto_ram #(
    .WIDTH (32),
    .DEPTH (WINDOW_LEN)
  ) u_window_ram (
    .clk     (clk),
    .wr_en   (retire),
    .wr_addr (window_pos),
    .wr_data (load_val),
    .rd_en   (accept),
    .rd_addr (window_pos),
    .rd_data (ram_rdata)
  );

  // Multiplier operand chunks: two unsigned 16-bit pieces, then the signed top two bits.
  always_comb begin
    case (mul_cnt)
      2'd0:    chunk = $signed({1'b0, mul_b[15:0]});
      2'd1:    chunk = $signed({1'b0, mul_b[31:16]});
      default: chunk = $signed({{15{mul_b[33]}}, mul_b[33:32]});
    endcase
  end

  // Partial products are registered and accumulated in the cycle after they are formed.
  always_comb begin
    case (mul_cnt)
      2'd1:    acc_sum = 68'(prod);
      2'd2:    acc_sum = acc + (68'(prod) <<< 16);
      2'd3:    acc_sum = acc + (68'(prod) <<< 32);
      default: acc_sum = acc;
    endcase
  end

  // Load correction and clamp to the configured bound, inclusive on both sides.
  always_comb begin
    lim_pos  = $signed({18'b0, load_limit});
    load_sum = 49'(load_est) + 49'($signed(acc[63:16]));
    if (load_sum > lim_pos) begin
      load_clamped = lim_pos[31:0];
    end else if (load_sum < -lim_pos) begin
      load_clamped = q16_t'(-lim_pos);
    end else begin
      load_clamped = load_sum[31:0];
    end
  end

  // Speed update with saturation to the signed 32-bit range.
  always_comb begin
    speed_sum = 50'(speed_est) + 50'($signed(acc[64:24])) + 50'(corr);
    if (speed_sum > 50'sd2147483647) begin
      speed_sat = 32'sh7fff_ffff;
    end else if (speed_sum < -50'sd2147483648) begin
      speed_sat = 32'sh8000_0000;
    end else begin
      speed_sat = speed_sum[31:0];
    end
  end

  // Running total of the window; an entry never written since reset counts as zero.
  assign old_entry = win_valid[window_pos] ? $signed(ram_rdata) : 32'sd0;
  assign total_sum = window_total - TOT_W'(old_entry) + TOT_W'(load_val);
  assign total_mag = total_sum[TOT_W-1] ? TOT_W'(-total_sum) : TOT_W'(total_sum);

  // Restoring division of the total magnitude by the window length, eight bits per cycle.
  // The remainder stays below the divisor, so each step is a narrow compare and subtract.
  always_comb begin
    logic [REM_W-1:0] rem_v;
    logic [DIV_W-1:0] q_v;
    rem_v = div_rem;
    q_v   = div_q;
    for (int k = 0; k < 8; k++) begin
      rem_v = {rem_v[REM_W-2:0], q_v[DIV_W-1]};
      q_v   = {q_v[DIV_W-2:0], 1'b0};
      if (rem_v >= DIVISOR) begin
        rem_v  = rem_v - DIVISOR;
        q_v[0] = 1'b1;
      end
    end
    div_q_step   = q_v;
    div_rem_step = rem_v;
  end

  // The quotient is truncated toward zero, so the sign is applied to the magnitude result.
  assign quot = div_q[31:0];
  assign avg  = div_neg ? $signed(~quot + 32'd1) : $signed(quot);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (accept) state_next = S_MUL_ERR;
      S_MUL_ERR:   if (mul_cnt == 2'd3) state_next = S_SET_LOADG;
      S_SET_LOADG: state_next = S_MUL_LOADG;
      S_MUL_LOADG: if (mul_cnt == 2'd3) state_next = S_CLAMP;
      S_CLAMP:     state_next = S_MUL_SPDG;
      S_MUL_SPDG:  if (mul_cnt == 2'd3) state_next = S_SET_TORQ;
      S_SET_TORQ:  state_next = S_MUL_TORQ;
      S_MUL_TORQ:  if (mul_cnt == 2'd3) state_next = S_SUM;
      S_SUM:       state_next = S_DIVIDE;
      S_DIVIDE:    if (div_cnt == DCNT_LAST) state_next = S_FINISH;
      S_FINISH:    if (retire) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Control state, configuration and observer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      mul_cnt             <= 2'd0;
      div_cnt             <= '0;
      speed_gain          <= '0;
      load_gain           <= '0;
      sample_period       <= SAMPLE_PER_RST;
      period_over_inertia <= PER_OVER_INR_RST;
      load_limit          <= LOAD_LIMIT_RST;
      speed_est           <= '0;
      load_est            <= '0;
      window_total        <= '0;
      window_pos          <= '0;
      win_valid           <= '0;
      estimate_valid      <= 1'b0;
    end else begin
      state <= state_next;

      if (mul_active) begin
        mul_cnt <= mul_cnt + 2'd1;
      end

      if (state == S_DIVIDE) begin
        div_cnt <= (div_cnt == DCNT_LAST) ? '0 : div_cnt + DCNT_W'(1);
      end

      if (cfg_write) begin
        case (cfg_index)
          REG_SPEED_GAIN:   speed_gain          <= $signed(cfg_data);
          REG_LOAD_GAIN:    load_gain           <= $signed(cfg_data);
          REG_SAMPLE_PER:   sample_period       <= cfg_data;
          REG_PER_OVER_INR: period_over_inertia <= cfg_data;
          REG_LOAD_LIMIT:   load_limit          <= cfg_data[30:0];
          default: ;
        endcase
      end

      // A retiring transaction refills the output register in the same cycle that the
      // previous estimate is taken.
      if (retire) begin
        estimate_valid        <= 1'b1;
        speed_est             <= speed_new;
        load_est              <= avg;
        window_total          <= total_upd;
        win_valid[window_pos] <= 1'b1;
        window_pos            <= (window_pos == POS_LAST) ? '0 : window_pos + POS_W'(1);
      end else if (estimate_valid && !estimate_stall) begin
        estimate_valid <= 1'b0;
      end
    end
  end

  // Payload datapath.
  always_ff @(posedge clk) begin
    if (accept) begin
      torque <= drive_torque;
      mul_a  <= 34'(measured_speed) - 34'(speed_est);
      mul_b  <= $signed({2'b0, sample_period});
    end

    if (mul_active) begin
      prod <= mul_a * chunk;
      acc  <= acc_sum;
    end

    case (state)
      S_SET_LOADG: begin
        err   <= $signed(acc[65:32]);
        mul_a <= 34'(load_gain);
        mul_b <= $signed(acc[65:32]);
      end
      S_CLAMP: begin
        load_val <= load_clamped;
        mul_a    <= 34'(speed_gain);
        mul_b    <= err;
      end
      S_SET_TORQ: begin
        corr  <= $signed(acc[63:16]);
        mul_a <= 34'(torque) - 34'(load_val);
        mul_b <= $signed({2'b0, period_over_inertia});
      end
      S_SUM: begin
        speed_new <= speed_sat;
        total_upd <= total_sum;
        div_neg   <= total_sum[TOT_W-1];
        div_q     <= DIV_W'(total_mag);
        div_rem   <= '0;
      end
      S_DIVIDE: begin
        div_q   <= div_q_step;
        div_rem <= div_rem_step;
      end
      default: ;
    endcase

    if (retire) begin
      speed_estimate <= speed_new;
      load_estimate  <= avg;
    end
  end

endmodule

// File: rtl/core/mlto_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mlto_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
